@@ hw/rtl/tpsc_pkg.sv @@
// Shared types and constants of the tick-period PI speed controller.
// Used by the register file, the controller, the datapath and the top level.
// No dependencies.
package tpsc_pkg;

    localparam int TickW  = 16;
    localparam int ScaleW = 24;
    localparam int WordW  = 16;
    localparam int GainW  = 32;
    localparam int IntW   = 48;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    localparam int DivSteps = ScaleW;
    localparam int CntW     = $clog2(DivSteps);

    localparam logic [ScaleW-1:0] ScaleRst  = 24'd3296077;
    localparam logic [WordW-1:0]  TargetRst = 16'd384;
    localparam logic [WordW-1:0]  PropRst   = 16'd1200;
    localparam logic [GainW-1:0]  IntegRst  = 32'd1288490;
    localparam logic [WordW-1:0]  DutyRst   = 16'd110;
    localparam logic [WordW-1:0]  PwmRst    = 16'd1000;

    typedef enum logic [2:0] {
        REG_SCALE  = 3'd0,
        REG_TARGET = 3'd1,
        REG_PROP   = 3'd2,
        REG_INTEG  = 3'd3,
        REG_DUTY   = 3'd4,
        REG_PWM    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [ScaleW-1:0] speed_scale;
        logic [WordW-1:0]  target_speed;
        logic [WordW-1:0]  prop_gain;
        logic [GainW-1:0]  integral_gain;
        logic [WordW-1:0]  open_loop_duty;
        logic [WordW-1:0]  pwm_period;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic div_step;
        logic err;
        logic mul_ep;
        logic acc;
        logic abs_val;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic drive;
        logic zero;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic period_zero;
    } t_status;

endpackage

@@ hw/rtl/tpsc_regs.sv @@
// APB-style configuration register file of the speed controller.
// Depends on tpsc_pkg for the register map, reset values and the t_cfg type.
module tpsc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpsc_pkg::AddrW-1:0]    paddr,
    input  logic [tpsc_pkg::DataW-1:0]    pwdata,
    output logic [tpsc_pkg::DataW-1:0]    prdata,
    output logic                          pready,
    output tpsc_pkg::t_cfg                o_cfg
);

    tpsc_pkg::t_cfg r_cfg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_scale    <= tpsc_pkg::ScaleRst;
            r_cfg.target_speed   <= tpsc_pkg::TargetRst;
            r_cfg.prop_gain      <= tpsc_pkg::PropRst;
            r_cfg.integral_gain  <= tpsc_pkg::IntegRst;
            r_cfg.open_loop_duty <= tpsc_pkg::DutyRst;
            r_cfg.pwm_period     <= tpsc_pkg::PwmRst;
        end else if (wr_en) begin
            case (idx)
                tpsc_pkg::REG_SCALE:  r_cfg.speed_scale    <= pwdata[tpsc_pkg::ScaleW-1:0];
                tpsc_pkg::REG_TARGET: r_cfg.target_speed   <= pwdata[tpsc_pkg::WordW-1:0];
                tpsc_pkg::REG_PROP:   r_cfg.prop_gain      <= pwdata[tpsc_pkg::WordW-1:0];
                tpsc_pkg::REG_INTEG:  r_cfg.integral_gain  <= pwdata[tpsc_pkg::GainW-1:0];
                tpsc_pkg::REG_DUTY:   r_cfg.open_loop_duty <= pwdata[tpsc_pkg::WordW-1:0];
                tpsc_pkg::REG_PWM:    r_cfg.pwm_period     <= pwdata[tpsc_pkg::WordW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            tpsc_pkg::REG_SCALE:  prdata = {8'd0, r_cfg.speed_scale};
            tpsc_pkg::REG_TARGET: prdata = {16'd0, r_cfg.target_speed};
            tpsc_pkg::REG_PROP:   prdata = {16'd0, r_cfg.prop_gain};
            tpsc_pkg::REG_INTEG:  prdata = r_cfg.integral_gain;
            tpsc_pkg::REG_DUTY:   prdata = {16'd0, r_cfg.open_loop_duty};
            tpsc_pkg::REG_PWM:    prdata = {16'd0, r_cfg.pwm_period};
            default:              prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/tpsc_ctrl.sv @@
// Sequencing state machine of the speed controller.
// Depends on tpsc_pkg for the command and status structs.
module tpsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick_valid,
    output logic                o_tick_ready,
    output logic                o_result_valid,
    input  logic                i_result_ready,
    input  tpsc_pkg::t_status   i_status,
    output tpsc_pkg::t_cmd      o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DIV   = 12'b0000_0000_0010,
        S_ERR   = 12'b0000_0000_0100,
        S_MULEP = 12'b0000_0000_1000,
        S_ACC   = 12'b0000_0001_0000,
        S_ABS   = 12'b0000_0010_0000,
        S_MLO   = 12'b0000_0100_0000,
        S_MHI   = 12'b0000_1000_0000,
        S_SUM   = 12'b0001_0000_0000,
        S_DRV   = 12'b0010_0000_0000,
        S_ZERO  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [tpsc_pkg::CntW-1:0]   r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        accept;
    logic                        out_free;

    assign o_tick_ready   = (r_state == S_IDLE);
    assign accept         = o_tick_ready & i_tick_valid;
    assign out_free       = !r_out_valid || i_result_ready;
    assign o_result_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.err      = (r_state == S_ERR);
        o_cmd.mul_ep   = (r_state == S_MULEP);
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.abs_val  = (r_state == S_ABS);
        o_cmd.mul_lo   = (r_state == S_MLO);
        o_cmd.mul_hi   = (r_state == S_MHI);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.drive    = (r_state == S_DRV);
        o_cmd.zero     = (r_state == S_ZERO);
        o_cmd.out_load = (r_state == S_OUT) && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_result_ready ? 1'b0 : r_out_valid);
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    n_state = i_status.period_zero ? S_ZERO : S_DIV;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == tpsc_pkg::CntW'(tpsc_pkg::DivSteps - 1)) begin
                    n_state = S_ERR;
                end
            end
            S_ERR:   n_state = S_MULEP;
            S_MULEP: n_state = S_ACC;
            S_ACC:   n_state = S_ABS;
            S_ABS:   n_state = S_MLO;
            S_MLO:   n_state = S_MHI;
            S_MHI:   n_state = S_SUM;
            S_SUM:   n_state = S_DRV;
            S_DRV:   n_state = S_OUT;
            S_ZERO:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/tpsc_dp.sv @@
// Datapath of the speed controller: serial divider, error integral, shared
// gain multiplier, drive sum and clamp, output registers.
// Depends on tpsc_pkg for widths, t_cfg, t_cmd and t_status.
module tpsc_dp #(
    parameter int PERIOD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tpsc_pkg::TickW-1:0]    i_tick_period,
    input  tpsc_pkg::t_cfg                i_cfg,
    input  tpsc_pkg::t_cmd                i_cmd,
    output tpsc_pkg::t_status             o_status,
    output logic [tpsc_pkg::WordW-1:0]    o_duty_value,
    output logic [tpsc_pkg::WordW-1:0]    o_measured_speed
);

    localparam int PW   = (PERIOD_BITS < tpsc_pkg::TickW) ? PERIOD_BITS : tpsc_pkg::TickW;
    localparam int SW   = tpsc_pkg::ScaleW;
    localparam int WW   = tpsc_pkg::WordW;
    localparam int EW   = WW + 1;
    localparam int EpW  = EW + PW + 1;
    localparam int PrW  = 2 * EW;
    localparam int IW   = tpsc_pkg::IntW;
    localparam int HW   = IW / 2;
    localparam int MW   = HW + tpsc_pkg::GainW;
    localparam int DW   = IW + 2;

    logic [PW-1:0]          r_period;
    logic [SW-1:0]          r_quo;
    logic [PW:0]            r_rem;
    logic [WW-1:0]          r_speed;
    logic signed [EW-1:0]   r_err;
    logic signed [EpW-1:0]  r_ep;
    logic signed [IW-1:0]   r_integ;
    logic signed [PrW-1:0]  r_prop;
    logic                   r_neg;
    logic [IW-1:0]          r_mag;
    logic [MW-1:0]          r_t;
    logic [MW-1:0]          r_a;
    logic signed [IW:0]     r_iterm;
    logic [WW-1:0]          r_duty;
    logic [WW-1:0]          r_out_duty;
    logic [WW-1:0]          r_out_speed;

    logic [PW-1:0]          period_in;
    logic [PW:0]            rem_shift;
    logic                   rem_ge;
    logic [WW-1:0]          speed_sat;
    logic signed [IW:0]     acc_sum;
    logic [HW-1:0]          mul_op;
    logic [MW-1:0]          mul_prod;
    logic [MW:0]            itm_sum;
    logic [IW-1:0]          itm;
    logic signed [DW-1:0]   drive;
    logic [WW-1:0]          top;
    logic signed [DW-1:0]   top_q;

    assign period_in            = i_tick_period[PW-1:0];
    assign o_status.period_zero = (period_in == '0);
    assign o_duty_value         = r_out_duty;
    assign o_measured_speed     = r_out_speed;

    assign rem_shift = {r_rem[PW-1:0], r_quo[SW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_period});
    assign speed_sat = (|r_quo[SW-1:WW]) ? {WW{1'b1}} : r_quo[WW-1:0];

    assign acc_sum = {r_integ[IW-1], r_integ} + (IW+1)'(r_ep);

    assign mul_op   = i_cmd.mul_hi ? r_mag[IW-1:HW] : r_mag[HW-1:0];
    assign mul_prod = MW'(mul_op) * MW'(i_cfg.integral_gain);

    assign itm_sum = {1'b0, r_a} + (MW+1)'(r_t[MW-1:HW]);
    assign itm     = itm_sum[IW+7:8];

    assign drive = $signed(DW'({i_cfg.open_loop_duty, 8'd0}))
                 + DW'(r_prop) + DW'(r_iterm);
    assign top   = (i_cfg.pwm_period == '0) ? '0 : i_cfg.pwm_period - 1'b1;
    assign top_q = $signed(DW'({top, 8'd0}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_period <= period_in;
            r_quo    <= i_cfg.speed_scale;
            r_rem    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_shift - {1'b0, r_period} : rem_shift;
            r_quo <= {r_quo[SW-2:0], rem_ge};
        end
        if (i_cmd.err) begin
            r_speed <= speed_sat;
            r_err   <= $signed({1'b0, i_cfg.target_speed}) - $signed({1'b0, speed_sat});
        end
        if (i_cmd.mul_ep) begin
            r_ep <= EpW'(r_err) * $signed(EpW'({1'b0, r_period}));
        end
        if (i_cmd.acc) begin
            r_prop <= PrW'($signed({1'b0, i_cfg.prop_gain})) * PrW'(r_err);
        end
        if (i_cmd.abs_val) begin
            r_neg <= r_integ[IW-1];
            r_mag <= r_integ[IW-1] ? IW'(-r_integ) : IW'(r_integ);
        end
        if (i_cmd.mul_lo) begin
            r_t <= mul_prod;
        end
        if (i_cmd.mul_hi) begin
            r_a <= mul_prod;
        end
        if (i_cmd.sum) begin
            r_iterm <= r_neg ? -$signed({1'b0, itm}) : $signed({1'b0, itm});
        end
        if (i_cmd.drive) begin
            if (drive > top_q) begin
                r_duty <= top;
            end else if (drive < 0) begin
                r_duty <= '0;
            end else begin
                r_duty <= drive[WW+7:8];
            end
        end
        if (i_cmd.zero) begin
            r_duty  <= i_cfg.open_loop_duty;
            r_speed <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_duty  <= r_duty;
            r_out_speed <= r_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_cmd.zero) begin
            r_integ <= '0;
        end else if (i_cmd.acc) begin
            if (acc_sum[IW] != acc_sum[IW-1]) begin
                r_integ <= acc_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
            end else begin
                r_integ <= acc_sum[IW-1:0];
            end
        end
    end

endmodule

@@ hw/rtl/tick_period_pi_speed_control_core.sv @@
// Top level of the tick-period PI speed controller.
// Instantiates tpsc_regs, tpsc_ctrl and tpsc_dp; uses tpsc_pkg.
//
//   Channel   Direction   Handshake                        Payload
//   tick      in          i_tick_valid / o_tick_ready      i_tick_period
//   result    out         o_result_valid / i_result_ready  o_duty_value, o_measured_speed
//   config    in          psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// A request with a nonzero period runs the one-bit-per-cycle restoring divider and
// then the error, integral, gain-multiply, sum and drive steps before the next
// request can be accepted. A zero period skips these and loads the open-loop duty.
// A finished result waits in the output register; the next request is accepted and
// worked on meanwhile, and only its final load stalls until the result is taken.
// Reset clears the controller, the output valid flag and the error integral.
module tick_period_pi_speed_control_core #(
    parameter int PERIOD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick_valid,
    output logic                          o_tick_ready,
    input  logic [tpsc_pkg::TickW-1:0]    i_tick_period,
    output logic                          o_result_valid,
    input  logic                          i_result_ready,
    output logic [tpsc_pkg::WordW-1:0]    o_duty_value,
    output logic [tpsc_pkg::WordW-1:0]    o_measured_speed,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpsc_pkg::AddrW-1:0]    paddr,
    input  logic [tpsc_pkg::DataW-1:0]    pwdata,
    output logic [tpsc_pkg::DataW-1:0]    prdata,
    output logic                          pready
);

    tpsc_pkg::t_cfg    cfg;
    tpsc_pkg::t_cmd    cmd;
    tpsc_pkg::t_status status;

    tpsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tpsc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_valid   (i_tick_valid),
        .o_tick_ready   (o_tick_ready),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    tpsc_dp #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick_period    (i_tick_period),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_duty_value     (o_duty_value),
        .o_measured_speed (o_measured_speed)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick_valid && o_tick_ready |=> !o_tick_ready)
        else $error("controller ready right after accepting a request");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick_valid && o_tick_ready |=> !cmd.out_load)
        else $error("result loaded one cycle after acceptance");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_result_valid)
        else $error("output load did not raise result valid");

    a_duty_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_measured_speed != '0) |->
            (o_duty_value < cfg.pwm_period) || (o_duty_value == '0))
        else $error("measured result duty exceeds PWM period");
`endif

endmodule
